FILE: hw/rtl/scfp_pkg.sv
// package for the serial command frame parser
// holds field widths, config indexes and reset values, position and status codes and the result beat type
// no dependencies
`timescale 1ns / 1ps

package scfp_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // payload capacity default, legal range 1 to 8
    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int LANES_MAX         = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'd1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd1;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd4;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_WAIT    = 9'd0;
    localparam logic [POS_W-1:0] POS_LENGTH  = 9'd1;
    localparam logic [POS_W-1:0] POS_COMMAND = 9'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd3;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_END  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // one finished frame
    typedef struct packed {
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   length;
        logic [WORD_W-1:0]   payload_low;
        logic [WORD_W-1:0]   payload_high;
        logic [STATUS_W-1:0] status;
    } t_frame;

endpackage

FILE: hw/rtl/serial_command_frame_parser.sv
// serial command frame parser: start, length, command, payload, end marker
// one byte a beat in, one frame summary beat out per finished frame
// depends on scfp_pkg
`timescale 1ns / 1ps

// channel   direction  handshake                         payload
// rx        in         i_rx_valid / o_rx_stall           i_rx_byte
// frame     out        o_frame_valid / i_frame_stall     o_frame_command, o_frame_length,
//                                                        o_payload_low, o_payload_high,
//                                                        o_frame_status
// cfg       in         i_cfg_we                          i_cfg_index, i_cfg_data
//
// one byte is taken every cycle unless stalled; frame beats are registered
// the rate is set by the single position register update done per byte
// a two-deep output stage (output register plus skid) keeps rx open while a frame waits
// o_rx_stall rises only when both output entries hold frames
// synchronous active-low reset returns to waiting for a start marker, markers to 1 and 4

module serial_command_frame_parser #(
    parameter int PAYLOAD_BYTES = scfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_rx_valid,
    output logic                              o_rx_stall,
    input  logic [scfp_pkg::BYTE_W-1:0]       i_rx_byte,
    // frame output
    output logic                              o_frame_valid,
    input  logic                              i_frame_stall,
    output logic [scfp_pkg::BYTE_W-1:0]       o_frame_command,
    output logic [scfp_pkg::BYTE_W-1:0]       o_frame_length,
    output logic [scfp_pkg::WORD_W-1:0]       o_payload_low,
    output logic [scfp_pkg::WORD_W-1:0]       o_payload_high,
    output logic [scfp_pkg::STATUS_W-1:0]     o_frame_status,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import scfp_pkg::*;

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // configuration and parse state
    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_length;
    logic [BYTE_W-1:0] r_command;
    logic [BYTE_W-1:0] r_store [PAYLOAD_BYTES];

    // output stage
    t_frame r_out, r_skid;
    logic   r_out_valid, r_skid_valid;

    logic                   rx_take;
    logic                   out_take;
    logic [POS_W-1:0]       end_pos;
    logic [POS_W-1:0]       store_idx;
    logic                   in_payload;
    logic                   at_end;
    logic                   store_we;
    logic                   res_valid;
    t_frame                 res;
    logic [LANES_MAX*BYTE_W-1:0] lanes;

    assign rx_take  = i_rx_valid & ~o_rx_stall;
    assign out_take = r_out_valid & ~i_frame_stall;

    // frame position decode
    assign end_pos    = {1'b0, r_length} + POS_PAYLOAD;
    assign store_idx  = r_pos - POS_PAYLOAD;
    assign in_payload = (r_pos >= POS_PAYLOAD) && (r_pos < end_pos);
    assign at_end     = (r_pos >= POS_PAYLOAD) && !(r_pos < end_pos);
    assign store_we   = rx_take && in_payload && (store_idx < POS_W'(PAYLOAD_BYTES));
    assign res_valid  = rx_take && at_end;

    // next position
    always_comb begin
        n_pos = r_pos;
        if (r_pos == POS_WAIT) begin
            if (i_rx_byte == r_start_marker) begin
                n_pos = POS_LENGTH;
            end
        end else if (r_pos == POS_LENGTH) begin
            n_pos = POS_COMMAND;
        end else if (r_pos == POS_COMMAND) begin
            n_pos = POS_PAYLOAD;
        end else if (in_payload) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = POS_WAIT;
        end
    end

    // payload lanes, zero beyond the length or the capacity
    for (genvar k = 0; k < LANES_MAX; k++) begin : g_lane
        if (k < PAYLOAD_BYTES) begin : g_used
            assign lanes[k*BYTE_W +: BYTE_W] =
                (r_length > BYTE_W'(k)) ? r_store[k] : '0;
        end else begin : g_zero
            assign lanes[k*BYTE_W +: BYTE_W] = '0;
        end
    end

    // result assembly
    always_comb begin
        res.command      = r_command;
        res.length       = r_length;
        res.payload_low  = lanes[WORD_W-1:0];
        res.payload_high = lanes[2*WORD_W-1:WORD_W];
        if (i_rx_byte != r_end_marker) begin
            res.status = STATUS_BAD_END;
        end else if (r_length > BYTE_W'(PAYLOAD_BYTES)) begin
            res.status = STATUS_OVERFLOW;
        end else begin
            res.status = STATUS_GOOD;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_WAIT;
            r_length  <= '0;
            r_command <= '0;
        end else if (rx_take) begin
            r_pos <= n_pos;
            if (r_pos == POS_LENGTH) begin
                r_length <= i_rx_byte;
            end
            if (r_pos == POS_COMMAND) begin
                r_command <= i_rx_byte;
            end
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    // ports
    assign o_rx_stall      = r_skid_valid;
    assign o_frame_valid   = r_out_valid;
    assign o_frame_command = r_out.command;
    assign o_frame_length  = r_out.length;
    assign o_payload_low   = r_out.payload_low;
    assign o_payload_high  = r_out.payload_high;
    assign o_frame_status  = r_out.status;

endmodule

FILE: dv/scfp_frame_checker.sv
// checker for the serial command frame parser: tracks markers and parse state,
// predicts each frame summary beat and compares it field by field
// depends on scfp_pkg
`timescale 1ns / 1ps

module scfp_frame_checker #(
    parameter int PAYLOAD_BYTES = scfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte channel, observed
    input  logic                              i_rx_valid,
    input  logic                              i_rx_stall,
    input  logic [scfp_pkg::BYTE_W-1:0]       i_rx_byte,
    // frame channel, observed
    input  logic                              i_frame_valid,
    input  logic                              i_frame_stall,
    input  logic [scfp_pkg::BYTE_W-1:0]       i_frame_command,
    input  logic [scfp_pkg::BYTE_W-1:0]       i_frame_length,
    input  logic [scfp_pkg::WORD_W-1:0]       i_payload_low,
    input  logic [scfp_pkg::WORD_W-1:0]       i_payload_high,
    input  logic [scfp_pkg::STATUS_W-1:0]     i_frame_status,
    // configuration writes, observed
    input  logic                              i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // to the testbench top
    output int                                o_fail_count,
    output int                                o_frames_due
);

    import scfp_pkg::*;

    // shadow of the marker registers and the parse state
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
    logic [POS_W-1:0]  parse_pos;
    logic [BYTE_W-1:0] held_len;
    logic [BYTE_W-1:0] held_cmd;
    logic [BYTE_W-1:0] payload_store [LANES_MAX];

    // frame summaries predicted but not yet seen on the output
    t_frame frames_due [$];

    initial begin
        o_fail_count = 0;
        o_frames_due = 0;
    end

    // summary of the frame closed by the byte at the end position
    function automatic t_frame close_frame(input logic [BYTE_W-1:0] end_byte);
        t_frame f;
        int     used;
        int     k;
        used = (int'(held_len) > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(held_len);
        f.command      = held_cmd;
        f.length       = held_len;
        f.payload_low  = '0;
        f.payload_high = '0;
        // lanes at or past the used count stay zero
        for (k = 0; k < 4; k++) begin
            if (k < used)
                f.payload_low[8*k +: 8] = payload_store[k];
            if (k + 4 < used)
                f.payload_high[8*k +: 8] = payload_store[k + 4];
        end
        // a wrong end byte wins over overflow
        if (end_byte != end_marker)
            f.status = STATUS_BAD_END;
        else if (int'(held_len) > PAYLOAD_BYTES)
            f.status = STATUS_OVERFLOW;
        else
            f.status = STATUS_GOOD;
        return f;
    endfunction

    // one received byte through the parser
    function automatic void advance_parser(input logic [BYTE_W-1:0] b);
        int slot;
        case (parse_pos)
            POS_WAIT: begin
                if (b == start_marker)
                    parse_pos = POS_LENGTH;
            end
            POS_LENGTH: begin
                held_len  = b;
                parse_pos = POS_COMMAND;
            end
            POS_COMMAND: begin
                held_cmd  = b;
                parse_pos = POS_PAYLOAD;
            end
            default: begin
                if (int'(parse_pos) < int'(held_len) + 3) begin
                    // bytes past capacity still count toward the end position
                    slot = int'(parse_pos) - int'(POS_PAYLOAD);
                    if (slot < PAYLOAD_BYTES)
                        payload_store[slot] = b;
                    parse_pos = parse_pos + 1'b1;
                end else begin
                    frames_due.push_back(close_frame(b));
                    parse_pos = POS_WAIT;
                end
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // compare one frame beat with the oldest prediction
    function automatic void check_frame_beat();
        t_frame want;
        if (frames_due.size() == 0) begin
            $error("frame beat with no frame expected");
            o_fail_count++;
        end else begin
            want = frames_due.pop_front();
            compare_field("frame_command", WORD_W'(want.command), WORD_W'(i_frame_command));
            compare_field("frame_length", WORD_W'(want.length), WORD_W'(i_frame_length));
            compare_field("payload_low", want.payload_low, i_payload_low);
            compare_field("payload_high", want.payload_high, i_payload_high);
            compare_field("frame_status", WORD_W'(want.status), WORD_W'(i_frame_status));
        end
    endfunction

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_marker = START_MARKER_RST;
            end_marker   = END_MARKER_RST;
            parse_pos    = POS_WAIT;
            held_len     = '0;
            held_cmd     = '0;
            frames_due.delete();
        end else begin
            // a frame beat never stems from the byte taken at the same edge
            if (i_frame_valid && !i_frame_stall)
                check_frame_beat();
            if (i_rx_valid && !i_rx_stall)
                advance_parser(i_rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_MARKER: start_marker = i_cfg_data;
                    CFG_END_MARKER:   end_marker   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_frames_due = frames_due.size();
    end

endmodule

FILE: dv/tb_serial_command_frame_parser.sv
// testbench top for the serial command frame parser: clock, reset, byte stimulus,
// marker writes, output stalls and the verdict
// depends on scfp_pkg, serial_command_frame_parser and scfp_frame_checker
`timescale 1ns / 1ps

module tb_serial_command_frame_parser;

    import scfp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int PHASE_BYTES  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 4;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} t_stall_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_rx_valid    = 1'b0;
    logic                  o_rx_stall;
    logic [BYTE_W-1:0]     i_rx_byte     = '0;
    logic                  o_frame_valid;
    logic                  i_frame_stall = 1'b0;
    logic [BYTE_W-1:0]     o_frame_command;
    logic [BYTE_W-1:0]     o_frame_length;
    logic [WORD_W-1:0]     o_payload_low;
    logic [WORD_W-1:0]     o_payload_high;
    logic [STATUS_W-1:0]   o_frame_status;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int frames_due;

    // sender state
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;
    bit                gaps_on;
    int                burst_left;
    int                bytes_sent;
    bit                long_hold_req;

    always #10 i_clk = ~i_clk;

    serial_command_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_frame_valid   (o_frame_valid),
        .i_frame_stall   (i_frame_stall),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length),
        .o_payload_low   (o_payload_low),
        .o_payload_high  (o_payload_high),
        .o_frame_status  (o_frame_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    scfp_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .i_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_valid   (o_frame_valid),
        .i_frame_stall   (i_frame_stall),
        .i_frame_command (o_frame_command),
        .i_frame_length  (o_frame_length),
        .i_payload_low   (o_payload_low),
        .i_payload_high  (o_payload_high),
        .i_frame_status  (o_frame_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_frames_due    (frames_due)
    );

    // one byte beat, with a random gap between bursts when gaps are on
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        if (burst_left > 0)
            burst_left--;
        bytes_sent++;
    endtask

    // whole frame; a negative fill means random payload, else fill, fill+1, ...
    task automatic drive_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
                               input int fill, input logic [BYTE_W-1:0] tail);
        int k;
        send_byte(cur_start);
        send_byte(len);
        send_byte(cmd);
        for (k = 0; k < int'(len); k++)
            send_byte((fill < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fill + k));
        send_byte(tail);
    endtask

    // let the block drain before touching the markers or ending
    task automatic settle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_MARKER;
        i_cfg_data  <= s;
        @(posedge i_clk);
        i_cfg_index <= CFG_END_MARKER;
        i_cfg_data  <= e;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_start = s;
        cur_end   = e;
    endtask

    // mostly well-formed frames with random content, some noise and cut-off frames
    task automatic run_phase(input int n_bytes);
        int               stop_at;
        int               pick;
        int               n;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] tail;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                n = $urandom_range(0, 99);
                if (n < 72)
                    len = BYTE_W'($urandom_range(0, PAYLOAD_BYTES_DEF));
                else if (n < 99)
                    len = BYTE_W'($urandom_range(PAYLOAD_BYTES_DEF + 1, PAYLOAD_BYTES_DEF + 4));
                else
                    len = BYTE_W'($urandom_range(PAYLOAD_BYTES_DEF + 5, 255));
                tail = ($urandom_range(0, 9) != 0) ? cur_end : BYTE_W'($urandom_range(0, 255));
                drive_frame(len, BYTE_W'($urandom_range(0, 255)), -1, tail);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                // frame cut short: what follows is taken as its remaining bytes
                send_byte(cur_start);
                repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver stall pattern, with one long hold on request
    initial begin
        t_stall_mode mode;
        int          seg_left;
        int          hold_left;
        mode      = RX_OPEN;
        seg_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_frame_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_stall_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:    i_frame_stall <= 1'b0;
                    RX_COIN:    i_frame_stall <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  i_frame_stall <= ($urandom_range(0, 3) == 0);
                    RX_CADENCE: i_frame_stall <= (seg_left % 3 != 0);
                    default:    i_frame_stall <= 1'b0;
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        cur_start     = START_MARKER_RST;
        cur_end       = END_MARKER_RST;
        gaps_on       = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        long_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle noise, empty frame, start marker inside a frame with a
        // wrong end byte equal to the start marker, full and short payloads,
        // overflow, and overflow with a wrong end byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_MARKER_RST);
        drive_frame(8'd0, 8'hFF, 0, cur_end);
        drive_frame(8'd2, cur_start, int'(cur_start), cur_start);
        send_byte(8'h02);
        drive_frame(8'd8, 8'h00, 8'hFF, cur_end);
        drive_frame(8'd3, 8'h5A, 8'h80, cur_end);
        drive_frame(8'd9, 8'hA5, 8'h10, cur_end);
        drive_frame(8'd9, 8'h3C, 8'h20, 8'h00);

        // reset markers, gaps on, then the output held off while frames keep coming
        gaps_on = 1'b1;
        run_phase(PHASE_BYTES);
        gaps_on       = 1'b0;
        long_hold_req = 1'b1;
        repeat (30)
            drive_frame(BYTE_W'($urandom_range(0, 2)), BYTE_W'($urandom_range(0, 255)), -1,
                        cur_end);
        gaps_on = 1'b1;
        settle();

        set_markers(8'h00, 8'hFF);
        run_phase(PHASE_BYTES);
        settle();

        // a stretch with no sender gaps
        set_markers(8'hFF, 8'h00);
        gaps_on = 1'b0;
        run_phase(PHASE_BYTES);
        settle();

        // the longest frame once
        set_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        gaps_on = 1'b1;
        drive_frame(8'hFF, BYTE_W'($urandom_range(0, 255)), -1, cur_end);
        run_phase(PHASE_BYTES);
        settle();

        // start and end markers equal
        set_markers(8'h7E, 8'h7E);
        run_phase(PHASE_BYTES);
        settle();

        if (frames_due != 0)
            $error("%0d frames never arrived", frames_due);
        if (fail_count == 0 && frames_due == 0)
            $display("serial_command_frame_parser regression: pass");
        else
            $display("serial_command_frame_parser regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("serial_command_frame_parser regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/scfp_pkg.sv
hw/rtl/serial_command_frame_parser.sv
dv/scfp_frame_checker.sv
dv/tb_serial_command_frame_parser.sv
